### hdl/wrfc_pkg.sv
`default_nettype none

package wrfc_pkg;

    // table size and derived widths
    localparam int MAX_RECORDS = 1024;
    localparam int ADDR_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int TOTAL_W     = $clog2(MAX_RECORDS + 1);
    localparam int CNT_W       = 11;
    localparam int NUM_CAT     = 4;
    localparam int CAT_W       = 4;
    localparam int CODES_W     = NUM_CAT * CAT_W;
    localparam int SCORE_W     = 16;
    localparam int REC_W       = CODES_W + SCORE_W;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request kind
    typedef enum logic {
        K_INSERT = 1'b0,
        K_QUERY  = 1'b1
    } t_kind;

    // classified request as it sits in the queue
    typedef struct packed {
        t_kind                kind;
        logic [CODES_W-1:0]   codes;
        logic [NUM_CAT-1:0]   mask;
        logic [SCORE_W-1:0]   score;
    } t_req;

    // back end sequencer
    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN
    } t_bstate;

endpackage

`default_nettype wire

### hdl/wrfc_front.sv
`default_nettype none

module wrfc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_req_type,
    input  wire logic [wrfc_pkg::CAT_W-1:0]   i_attr_a,
    input  wire logic [wrfc_pkg::CAT_W-1:0]   i_attr_b,
    input  wire logic [wrfc_pkg::CAT_W-1:0]   i_attr_c,
    input  wire logic [wrfc_pkg::CAT_W-1:0]   i_attr_d,
    input  wire logic [wrfc_pkg::NUM_CAT-1:0] i_wildcard_mask,
    input  wire logic [wrfc_pkg::SCORE_W-1:0] i_score,
    output wrfc_pkg::t_req                    o_head,
    output logic                              o_head_vld,
    input  wire logic                         i_pop
);
    import wrfc_pkg::*;

    t_req              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    t_req              req;

    // classify the incoming request
    always_comb begin
        req.codes = {i_attr_d, i_attr_c, i_attr_b, i_attr_a};
        req.score = i_score;
        unique case (i_req_type)
            1'b0: begin
                req.kind = K_INSERT;
                req.mask = '0;
            end
            1'b1: begin
                req.kind = K_QUERY;
                req.mask = i_wildcard_mask;
            end
            default: begin
                req.kind = K_INSERT;
                req.mask = '0;
            end
        endcase
    end

    // queue control
    assign busy       = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push       = start && !busy;
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_cnt    = r_cnt + QCNT_W'(push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= req;
        end
    end

endmodule

`default_nettype wire

### hdl/wrfc_back.sv
`default_nettype none

module wrfc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire wrfc_pkg::t_req             i_head,
    input  wire logic                       i_head_vld,
    output logic                            o_pop,
    output logic                            o_done,
    output logic [wrfc_pkg::CNT_W-1:0]      o_match_count
);
    import wrfc_pkg::*;

    // record table, entry = {score, attr_d, attr_c, attr_b, attr_a}
    logic [REC_W-1:0]   r_mem [MAX_RECORDS];
    logic [REC_W-1:0]   r_rd_data;
    logic               r_rd_vld;

    t_bstate            r_state, n_state;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_result, n_result;
    t_req               r_query, n_query;

    logic               full;
    logic               last;
    logic               mem_we;
    logic               rd_en;
    logic               q_load;
    logic               hit;

    // record against query: categories under mask, then minimum score
    function automatic logic rec_match(input logic [REC_W-1:0] rec, input t_req q);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < NUM_CAT; k++) begin
            if (!q.mask[k] && (rec[k*CAT_W +: CAT_W] != q.codes[k*CAT_W +: CAT_W])) begin
                ok = 1'b0;
            end
        end
        return ok && (rec[CODES_W +: SCORE_W] >= q.score);
    endfunction

    assign full = (r_total == TOTAL_W'(MAX_RECORDS));
    assign last = (TOTAL_W'(r_idx) == r_total - TOTAL_W'(1));
    assign hit  = r_rd_vld && rec_match(r_rd_data, r_query);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_head_vld && (i_head.kind == K_QUERY) && (r_total != '0)) begin
                    n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                if (last) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: begin
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        rd_en  = 1'b0;
        unique case (r_state)
            B_IDLE:  o_pop = i_head_vld;
            B_SCAN:  rd_en = 1'b1;
            B_DRAIN: rd_en = 1'b0;
            default: o_pop = 1'b0;
        endcase
    end

    assign mem_we = o_pop && (i_head.kind == K_INSERT) && !full;
    assign q_load = o_pop && (i_head.kind == K_QUERY);

    // datapath next values
    always_comb begin
        n_total  = mem_we ? r_total + TOTAL_W'(1) : r_total;
        n_query  = r_query;
        n_idx    = r_idx;
        n_count  = r_count + CNT_W'(hit);
        n_done   = 1'b0;
        n_result = r_result;
        if (q_load) begin
            n_query = i_head;
            n_idx   = '0;
            n_count = '0;
            if (r_total == '0) begin
                n_done   = 1'b1;
                n_result = '0;
            end
        end
        if (r_state == B_SCAN) begin
            n_idx = r_idx + ADDR_W'(1);
        end
        if (r_state == B_DRAIN) begin
            n_done   = 1'b1;
            n_result = r_count + CNT_W'(hit);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_total  <= '0;
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_done   <= n_done;
            r_rd_vld <= rd_en;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_query  <= n_query;
        r_idx    <= n_idx;
        r_count  <= n_count;
        r_result <= n_result;
    end

    // record table write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_total[ADDR_W-1:0]] <= {i_head.score, i_head.codes};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign o_done        = r_done;
    assign o_match_count = r_result;

endmodule

`default_nettype wire

### hdl/wildcard_record_filter_count.sv
// channel   | ports                                            | handshake
// ----------+--------------------------------------------------+------------------------------
// request   | i_req_type, i_attr_a..d, i_wildcard_mask, i_score | taken when start && !busy
// result    | o_match_count                                    | o_done high for one cycle
//
// a request enters a two-deep queue; the back end takes one request at a time
// an insert occupies the back end only in B_IDLE, as it is popped; a query goes on to B_SCAN
// (one table read per stored record), then B_DRAIN (last registered read and count update);
// a query on an empty table skips the scan and reports 0
// reset clears the record count and the queue; table contents are not cleared
// busy rises only while the queue is full; results cannot be held off
`default_nettype none

module wildcard_record_filter_count (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_req_type,
    input  wire logic [wrfc_pkg::CAT_W-1:0]   i_attr_a,
    input  wire logic [wrfc_pkg::CAT_W-1:0]   i_attr_b,
    input  wire logic [wrfc_pkg::CAT_W-1:0]   i_attr_c,
    input  wire logic [wrfc_pkg::CAT_W-1:0]   i_attr_d,
    input  wire logic [wrfc_pkg::NUM_CAT-1:0] i_wildcard_mask,
    input  wire logic [wrfc_pkg::SCORE_W-1:0] i_score,
    output logic                              o_done,
    output logic [wrfc_pkg::CNT_W-1:0]        o_match_count
);
    import wrfc_pkg::*;

    t_req head;
    logic head_vld;
    logic pop;

    // accept and classify
    wrfc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_attr_a        (i_attr_a),
        .i_attr_b        (i_attr_b),
        .i_attr_c        (i_attr_c),
        .i_attr_d        (i_attr_d),
        .i_wildcard_mask (i_wildcard_mask),
        .i_score         (i_score),
        .o_head          (head),
        .o_head_vld      (head_vld),
        .i_pop           (pop)
    );

    // store records and scan for queries
    wrfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_vld    (head_vld),
        .o_pop         (pop),
        .o_done        (o_done),
        .o_match_count (o_match_count)
    );

endmodule

`default_nettype wire
